// ===== hdl/pscomp_pkg.sv =====
// Shared types and constants for the pressure sensor compensation block.
package pscomp_pkg;

  // Field widths
  localparam int REG_W     = 16;
  localparam int D_W       = 24;
  localparam int P_W       = 26;
  localparam int T_W       = 19;
  localparam int CFG_IDX_W = 3;

  // Datapath depth in register stages
  localparam int NSTG      = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROM0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C4    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C5    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C6    = 3'd6;

  // CRC4 constants
  localparam logic [REG_W-1:0] CRC_POLY   = 16'h3000;
  localparam logic [REG_W-1:0] PROM0_MASK = 16'h0FFF;

  // Output saturation limits
  localparam logic signed [P_W-1:0] P_MAX = 26'sh1FFFFFF;
  localparam logic signed [P_W-1:0] P_MIN = 26'sh2000000;
  localparam logic signed [T_W-1:0] T_MAX = 19'sh3FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 19'sh40000;

  // Calibration words as held in the register file
  typedef struct packed {
    logic [REG_W-1:0] prom0;
    logic [REG_W-1:0] c1;
    logic [REG_W-1:0] c2;
    logic [REG_W-1:0] c3;
    logic [REG_W-1:0] c4;
    logic [REG_W-1:0] c5;
    logic [REG_W-1:0] c6;
  } coef_t;

  // CRC checker status
  typedef struct packed {
    logic busy;
    logic ok;
  } crc_stat_t;

endpackage

// ===== hdl/pscomp_cfg.sv =====
// Calibration register file with write decode.
module pscomp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pscomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pscomp_pkg::REG_W-1:0]   cfg_wdata,
  output pscomp_pkg::coef_t              coef,
  output logic                           wr_beat
);
  import pscomp_pkg::*;

  coef_t coef_r;

  assign cfg_ready = 1'b1;
  assign wr_beat   = cfg_valid;
  assign coef      = coef_r;

  // Write the addressed register, drop writes beyond the last index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROM0: coef_r.prom0 <= cfg_wdata;
        REG_C1:    coef_r.c1    <= cfg_wdata;
        REG_C2:    coef_r.c2    <= cfg_wdata;
        REG_C3:    coef_r.c3    <= cfg_wdata;
        REG_C4:    coef_r.c4    <= cfg_wdata;
        REG_C5:    coef_r.c5    <= cfg_wdata;
        REG_C6:    coef_r.c6    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/pscomp_crc.sv =====
// CRC4 check over the seven PROM words, one byte per cycle.
module pscomp_crc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pscomp_pkg::coef_t     coef,
  input  logic                  restart,
  output pscomp_pkg::crc_stat_t stat
);
  import pscomp_pkg::*;

  logic             busy_r;
  logic [3:0]       cnt_r;
  logic [REG_W-1:0] rem_r;
  logic [REG_W-1:0] rem_nxt;
  logic             ok_r;
  logic [REG_W-1:0] word;
  logic [7:0]       byte_sel;

  // Pick the word and byte for this sweep position
  always_comb begin
    case (cnt_r[3:1])
      3'd0:    word = coef.prom0 & PROM0_MASK;
      3'd1:    word = coef.c1;
      3'd2:    word = coef.c2;
      3'd3:    word = coef.c3;
      3'd4:    word = coef.c4;
      3'd5:    word = coef.c5;
      3'd6:    word = coef.c6;
      default: word = '0;
    endcase
    byte_sel = cnt_r[0] ? word[7:0] : word[15:8];
  end

  // Fold one byte into the remainder, eight bit steps
  always_comb begin
    rem_nxt = rem_r ^ {8'b0, byte_sel};
    for (int b = 0; b < 8; b++) begin
      if (rem_nxt[15]) begin
        rem_nxt = {rem_nxt[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        rem_nxt = {rem_nxt[14:0], 1'b0};
      end
    end
  end

  // Sweep sixteen bytes after reset and after every register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else if (restart) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Latch the match flag at the last byte
  always_ff @(posedge clk) begin
    if (busy_r && !restart && cnt_r == 4'd15) begin
      ok_r <= (rem_nxt[15:12] == coef.prom0[15:12]);
    end
  end

  assign stat.busy = busy_r;
  assign stat.ok   = ok_r;

endmodule

// ===== hdl/pscomp_dp.sv =====
// Ten-stage compensation datapath with per-stage valid bits.
module pscomp_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pscomp_pkg::D_W-1:0]       in_d1,
  input  logic [pscomp_pkg::D_W-1:0]       in_d2,
  input  logic                             in_crc_ok,
  input  pscomp_pkg::coef_t                coef,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pscomp_pkg::P_W-1:0] out_p,
  output logic signed [pscomp_pkg::T_W-1:0] out_t,
  output logic                             out_crc_ok
);
  import pscomp_pkg::*;

  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_nxt;
  logic [NSTG:1] en;

  // Stage 1
  logic signed [24:0] s1_dt_r, s1_dt_nxt;
  logic [D_W-1:0]     s1_d1_r;
  logic               s1_crc_r;
  // Stage 2
  logic signed [41:0] s2_c3dt_r, s2_c3dt_nxt;
  logic signed [41:0] s2_c4dt_r, s2_c4dt_nxt;
  logic signed [41:0] s2_c6dt_r, s2_c6dt_nxt;
  logic signed [49:0] dtsq_full;
  logic [47:0]        s2_dtsq_r, s2_dtsq_nxt;
  logic [D_W-1:0]     s2_d1_r;
  logic               s2_crc_r;
  // Stage 3
  logic signed [41:0] c3b, c4b, c6b;
  logic [49:0]        dtsq3;
  logic signed [39:0] s3_sens_r, s3_sens_nxt;
  logic signed [39:0] s3_off_r, s3_off_nxt;
  logic signed [17:0] s3_dtemp_r, s3_dtemp_nxt;
  logic [16:0]        s3_ti_r, s3_ti_nxt;
  logic [D_W-1:0]     s3_d1_r;
  logic               s3_crc_r;
  // Stage 4
  logic signed [35:0] sq_full;
  logic signed [19:0] t_wide;
  logic [33:0]        s4_sq_r, s4_sq_nxt;
  logic signed [T_W-1:0] s4_t_r, s4_t_nxt;
  logic               s4_neg_r;
  logic signed [39:0] s4_sens_r, s4_off_r;
  logic [D_W-1:0]     s4_d1_r;
  logic               s4_crc_r;
  // Stage 5
  logic [35:0]        sq3;
  logic [36:0]        sq5;
  logic [35:0]        offi;
  logic [33:0]        sensi;
  logic signed [35:0] s5_ssub_r, s5_ssub_nxt;
  logic signed [39:0] s5_ooff_r, s5_ooff_nxt;
  logic signed [T_W-1:0] s5_t_r;
  logic [D_W-1:0]     s5_d1_r;
  logic               s5_crc_r;
  // Stage 6
  logic [41:0]        s6_lo_r, s6_lo_nxt;
  logic signed [42:0] s6_hi_r, s6_hi_nxt;
  logic signed [39:0] s6_ooff_r;
  logic signed [T_W-1:0] s6_t_r;
  logic               s6_crc_r;
  // Stage 7
  logic signed [60:0] s7_prod_r, s7_prod_nxt;
  logic signed [39:0] s7_ooff_r;
  logic signed [T_W-1:0] s7_t_r;
  logic               s7_crc_r;
  // Stage 8
  logic signed [60:0] pb;
  logic signed [39:0] s8_q_r, s8_q_nxt;
  logic signed [39:0] s8_ooff_r;
  logic signed [T_W-1:0] s8_t_r;
  logic               s8_crc_r;
  // Stage 9
  logic signed [41:0] s9_diff_r, s9_diff_nxt;
  logic signed [T_W-1:0] s9_t_r;
  logic               s9_crc_r;
  // Stage 10
  logic signed [41:0] db;
  logic signed [28:0] p_wide;
  logic signed [P_W-1:0] s10_p_r, s10_p_nxt;
  logic signed [T_W-1:0] s10_t_r;
  logic               s10_crc_r;

  // Advance a stage when it is empty or the one after it advances
  always_comb begin
    en[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt  = {vld_r[NSTG-1:1], in_valid};
  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // Stage 1: dT = D2 - C5*256
  assign s1_dt_nxt = $signed({1'b0, in_d2}) - $signed({1'b0, coef.c5, 8'b0});

  // Stage 2: products of dT
  assign s2_c3dt_nxt = 42'(s1_dt_r) * 42'($signed({1'b0, coef.c3}));
  assign s2_c4dt_nxt = 42'(s1_dt_r) * 42'($signed({1'b0, coef.c4}));
  assign s2_c6dt_nxt = 42'(s1_dt_r) * 42'($signed({1'b0, coef.c6}));
  assign dtsq_full   = 50'(s1_dt_r) * 50'(s1_dt_r);
  assign s2_dtsq_nxt = dtsq_full[47:0];

  // Stage 3: SENS, OFF, TEMP-2000 and Ti, division truncating toward zero
  always_comb begin
    c3b = s2_c3dt_r + (s2_c3dt_r[41] ? 42'sd255 : 42'sd0);
    c4b = s2_c4dt_r + (s2_c4dt_r[41] ? 42'sd127 : 42'sd0);
    c6b = s2_c6dt_r + (s2_c6dt_r[41] ? 42'sd8388607 : 42'sd0);
    s3_sens_nxt  = $signed({9'b0, coef.c1, 15'b0}) + 40'(c3b >>> 8);
    s3_off_nxt   = $signed({8'b0, coef.c2, 16'b0}) + 40'(c4b >>> 7);
    s3_dtemp_nxt = 18'(c6b >>> 23);
    dtsq3        = {2'b0, s2_dtsq_r} + {1'b0, s2_dtsq_r, 1'b0};
    if (s3_dtemp_nxt[17]) begin
      s3_ti_nxt = dtsq3[49:33];
    end else begin
      s3_ti_nxt = {5'b0, s2_dtsq_r[47:36]};
    end
  end

  // Stage 4: square of TEMP-2000, final temperature with saturation
  always_comb begin
    sq_full   = 36'(s3_dtemp_r) * 36'(s3_dtemp_r);
    s4_sq_nxt = sq_full[33:0];
    t_wide    = 20'(s3_dtemp_r) + 20'sd2000 - $signed({3'b0, s3_ti_r});
    if (t_wide > 20'(T_MAX)) begin
      s4_t_nxt = T_MAX;
    end else if (t_wide < 20'(T_MIN)) begin
      s4_t_nxt = T_MIN;
    end else begin
      s4_t_nxt = T_W'(t_wide);
    end
  end

  // Stage 5: second-order offset and sensitivity terms
  always_comb begin
    sq3 = {2'b0, s4_sq_r} + {1'b0, s4_sq_r, 1'b0};
    sq5 = {3'b0, s4_sq_r} + {1'b0, s4_sq_r, 2'b0};
    if (s4_neg_r) begin
      offi  = {1'b0, sq3[35:1]};
      sensi = sq5[36:3];
    end else begin
      offi  = {6'b0, s4_sq_r[33:4]};
      sensi = '0;
    end
    s5_ssub_nxt = 36'(s4_sens_r - $signed({6'b0, sensi}));
    s5_ooff_nxt = s4_off_r - $signed({4'b0, offi});
  end

  // Stage 6: D1 times SENS2 in two partial products
  assign s6_lo_nxt = 42'(s5_d1_r) * 42'(s5_ssub_r[17:0]);
  assign s6_hi_nxt = 43'($signed({1'b0, s5_d1_r})) * 43'($signed(s5_ssub_r[35:18]));

  // Stage 7: combine partial products
  assign s7_prod_nxt = (61'(s6_hi_r) <<< 18) + $signed({19'b0, s6_lo_r});

  // Stage 8: divide by 2^21
  assign pb       = s7_prod_r + (s7_prod_r[60] ? 61'sd2097151 : 61'sd0);
  assign s8_q_nxt = 40'(pb >>> 21);

  // Stage 9: subtract OFF2
  assign s9_diff_nxt = 42'(s8_q_r) - 42'(s8_ooff_r);

  // Stage 10: divide by 8192 and saturate
  always_comb begin
    db     = s9_diff_r + (s9_diff_r[41] ? 42'sd8191 : 42'sd0);
    p_wide = 29'(db >>> 13);
    if (p_wide > 29'(P_MAX)) begin
      s10_p_nxt = P_MAX;
    end else if (p_wide < 29'(P_MIN)) begin
      s10_p_nxt = P_MIN;
    end else begin
      s10_p_nxt = P_W'(p_wide);
    end
  end

  // Load payload of each stage when it advances
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dt_r  <= s1_dt_nxt;
      s1_d1_r  <= in_d1;
      s1_crc_r <= in_crc_ok;
    end
    if (en[2]) begin
      s2_c3dt_r <= s2_c3dt_nxt;
      s2_c4dt_r <= s2_c4dt_nxt;
      s2_c6dt_r <= s2_c6dt_nxt;
      s2_dtsq_r <= s2_dtsq_nxt;
      s2_d1_r   <= s1_d1_r;
      s2_crc_r  <= s1_crc_r;
    end
    if (en[3]) begin
      s3_sens_r  <= s3_sens_nxt;
      s3_off_r   <= s3_off_nxt;
      s3_dtemp_r <= s3_dtemp_nxt;
      s3_ti_r    <= s3_ti_nxt;
      s3_d1_r    <= s2_d1_r;
      s3_crc_r   <= s2_crc_r;
    end
    if (en[4]) begin
      s4_sq_r   <= s4_sq_nxt;
      s4_t_r    <= s4_t_nxt;
      s4_neg_r  <= s3_dtemp_r[17];
      s4_sens_r <= s3_sens_r;
      s4_off_r  <= s3_off_r;
      s4_d1_r   <= s3_d1_r;
      s4_crc_r  <= s3_crc_r;
    end
    if (en[5]) begin
      s5_ssub_r <= s5_ssub_nxt;
      s5_ooff_r <= s5_ooff_nxt;
      s5_t_r    <= s4_t_r;
      s5_d1_r   <= s4_d1_r;
      s5_crc_r  <= s4_crc_r;
    end
    if (en[6]) begin
      s6_lo_r   <= s6_lo_nxt;
      s6_hi_r   <= s6_hi_nxt;
      s6_ooff_r <= s5_ooff_r;
      s6_t_r    <= s5_t_r;
      s6_crc_r  <= s5_crc_r;
    end
    if (en[7]) begin
      s7_prod_r <= s7_prod_nxt;
      s7_ooff_r <= s6_ooff_r;
      s7_t_r    <= s6_t_r;
      s7_crc_r  <= s6_crc_r;
    end
    if (en[8]) begin
      s8_q_r    <= s8_q_nxt;
      s8_ooff_r <= s7_ooff_r;
      s8_t_r    <= s7_t_r;
      s8_crc_r  <= s7_crc_r;
    end
    if (en[9]) begin
      s9_diff_r <= s9_diff_nxt;
      s9_t_r    <= s8_t_r;
      s9_crc_r  <= s8_crc_r;
    end
    if (en[10]) begin
      s10_p_r   <= s10_p_nxt;
      s10_t_r   <= s9_t_r;
      s10_crc_r <= s9_crc_r;
    end
  end

  assign out_valid  = vld_r[NSTG];
  assign out_p      = s10_p_r;
  assign out_t      = s10_t_r;
  assign out_crc_ok = s10_crc_r;

endmodule

// ===== hdl/pressure_sensor_compensation_top.sv =====
// Top level of the pressure sensor compensation block.
//
// Input channel (in_valid / in_stall) carries one raw pressure and one raw
// temperature conversion per beat. Output channel (out_valid / out_stall)
// returns compensated pressure in 0.1 mbar, temperature in 0.01 degC and
// the PROM CRC4 match flag, one beat per input beat, in order.
// Configuration port (cfg_valid / cfg_ready) writes the seven PROM words by
// index; cfg_ready is always high and writes beyond index six are dropped.
// Throughput is one beat per cycle while out_stall is low and no CRC sweep
// runs, set by the ten-stage datapath with at most one multiply level
// per stage and a two-part split of the wide D1 product.
// After reset and after every register write the CRC checker sweeps the
// sixteen PROM bytes one per cycle; in_stall is high while the sweep runs.
// A stalled output holds its beat; stages behind it keep filling any empty
// slots, so the pipeline stalls input only when every stage holds a beat.
module pressure_sensor_compensation_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pscomp_pkg::D_W-1:0]       in_raw_pressure,
  input  logic [pscomp_pkg::D_W-1:0]       in_raw_temperature,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pscomp_pkg::P_W-1:0] out_pressure_tenth_mbar,
  output logic signed [pscomp_pkg::T_W-1:0] out_temperature_centi,
  output logic                             out_crc_ok,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pscomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pscomp_pkg::REG_W-1:0]     cfg_wdata
);
  import pscomp_pkg::*;

  coef_t     coef;
  crc_stat_t crc_stat;
  logic      wr_beat;
  logic      dp_ready;
  logic      dp_in_valid;

  pscomp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef),
    .wr_beat   (wr_beat)
  );

  pscomp_crc u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef),
    .restart (wr_beat),
    .stat    (crc_stat)
  );

  // Hold input while the CRC sweep runs or the pipeline is full
  assign in_stall    = !dp_ready || crc_stat.busy;
  assign dp_in_valid = in_valid && !crc_stat.busy;

  pscomp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dp_in_valid),
    .in_ready   (dp_ready),
    .in_d1      (in_raw_pressure),
    .in_d2      (in_raw_temperature),
    .in_crc_ok  (crc_stat.ok),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_p      (out_pressure_tenth_mbar),
    .out_t      (out_temperature_centi),
    .out_crc_ok (out_crc_ok)
  );

endmodule

// ===== bench/tb_pressure_sensor_compensation_top.sv =====
// Self-checking testbench for the pressure sensor compensation top level.
module tb_pressure_sensor_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pscomp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // decoded by nothing
  localparam logic [D_W-1:0]       D_MAX     = '1;
  localparam int LONG_HOLD  = 200;
  localparam int SETTLE     = 12;
  localparam int END_WAIT   = 24;
  localparam int IDLE_LIMIT = 2000;

  // Compensated reading as it leaves the block
  typedef struct {
    logic signed [P_W-1:0] pressure;
    logic signed [T_W-1:0] temperature;
    logic                  crc_ok;
  } reading_t;

  // Predicts each compensated reading and checks the block's output against it
  class compensation_scoreboard;
    coef_t    cal = '0;
    reading_t pending_readings[$];
    int       mismatches = 0;
    int       checked = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_PROM0: cal.prom0 = val;
        REG_C1:    cal.c1 = val;
        REG_C2:    cal.c2 = val;
        REG_C3:    cal.c3 = val;
        REG_C4:    cal.c4 = val;
        REG_C5:    cal.c5 = val;
        REG_C6:    cal.c6 = val;
        default:   ;
      endcase
    endfunction

    // CRC4 over the seven PROM words, CRC nibble masked out, eighth word zero
    function logic [3:0] crc4_of(coef_t c);
      logic [REG_W-1:0] words [8];
      logic [REG_W-1:0] rem;
      logic [REG_W-1:0] w;
      words[0] = c.prom0 & PROM0_MASK;
      words[1] = c.c1;
      words[2] = c.c2;
      words[3] = c.c3;
      words[4] = c.c4;
      words[5] = c.c5;
      words[6] = c.c6;
      words[7] = '0;
      rem = '0;
      for (int i = 0; i < 16; i++) begin
        w = words[i / 2];
        rem = rem ^ ((i % 2 == 1) ? {8'h00, w[7:0]} : {8'h00, w[15:8]});
        for (int b = 0; b < 8; b++) begin
          rem = rem[15] ? ((rem << 1) ^ CRC_POLY) : (rem << 1);
        end
      end
      return rem[15:12];
    endfunction

    // Second-order compensation in signed 64-bit, truncating division
    function void note_input(logic [D_W-1:0] raw_p, logic [D_W-1:0] raw_t);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, sens, off, temp, dtemp, ti, offi, sensi, p, t;
      reading_t r;
      d1 = raw_p;
      d2 = raw_t;
      c1 = cal.c1;
      c2 = cal.c2;
      c3 = cal.c3;
      c4 = cal.c4;
      c5 = cal.c5;
      c6 = cal.c6;
      dt = d2 - c5 * 256;
      sens = c1 * 32768 + (c3 * dt) / 256;
      off = c2 * 65536 + (c4 * dt) / 128;
      temp = 2000 + (dt * c6) / 64'sd8388608;
      dtemp = temp - 2000;
      if (temp < 2000) begin
        ti = (3 * dt * dt) / 64'sd8589934592;
        offi = (3 * dtemp * dtemp) / 2;
        sensi = (5 * dtemp * dtemp) / 8;
      end else begin
        ti = (2 * dt * dt) / 64'sd137438953472;
        offi = (dtemp * dtemp) / 16;
        sensi = 0;
      end
      p = ((d1 * (sens - sensi)) / 64'sd2097152 - (off - offi)) / 64'sd8192;
      t = temp - ti;
      // saturate to the output field ranges
      if (p > P_MAX) p = P_MAX;
      if (p < P_MIN) p = P_MIN;
      if (t > T_MAX) t = T_MAX;
      if (t < T_MIN) t = T_MIN;
      r.pressure = p[P_W-1:0];
      r.temperature = t[T_W-1:0];
      r.crc_ok = (crc4_of(cal) == cal.prom0[15:12]);
      pending_readings.push_back(r);
    endfunction

    function void check_result(logic signed [P_W-1:0] p, logic signed [T_W-1:0] t,
                               logic ok);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected beat, pressure %0d temperature %0d crc_ok %0b",
                 $time, p, t, ok);
        mismatches++;
        return;
      end
      want = pending_readings.pop_front();
      checked++;
      if (p !== want.pressure) begin
        $display("%0t: pressure_tenth_mbar expected %0d, actual %0d",
                 $time, want.pressure, p);
        mismatches++;
      end
      if (t !== want.temperature) begin
        $display("%0t: temperature_centi expected %0d, actual %0d",
                 $time, want.temperature, t);
        mismatches++;
      end
      if (ok !== want.crc_ok) begin
        $display("%0t: crc_ok expected %0b, actual %0b", $time, want.crc_ok, ok);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [D_W-1:0]              in_raw_pressure = '0;
  logic [D_W-1:0]              in_raw_temperature = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [P_W-1:0]       out_pressure_tenth_mbar;
  logic signed [T_W-1:0]       out_temperature_centi;
  logic                        out_crc_ok;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [REG_W-1:0]            cfg_wdata = '0;

  compensation_scoreboard sb = new();
  int holds_asked = 0;
  int cal_sets = 0;
  int spare_writes = 0;

  pressure_sensor_compensation_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_raw_pressure         (in_raw_pressure),
    .in_raw_temperature      (in_raw_temperature),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_pressure_tenth_mbar (out_pressure_tenth_mbar),
    .out_temperature_centi   (out_temperature_centi),
    .out_crc_ok              (out_crc_ok),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result beat the block hands over
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_pressure_tenth_mbar, out_temperature_centi, out_crc_ok);
    end
  end

  // Abort when no beat moves on any port for too long
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no beat on any port for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall density in stretches, plus long hold-offs on request
  initial begin : receiver
    int holds_served;
    int pct;
    int left;
    holds_served = 0;
    pct = 0;
    left = 0;
    @(posedge clk);
    forever begin
      if (holds_asked != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left == 0) begin
          case ($urandom_range(3))
            0:       pct = 0;
            1:       pct = 20;
            2:       pct = 50;
            default: pct = 85;
          endcase
          left = $urandom_range(300, 40);
        end
        left--;
        out_stall <= ($urandom_range(99) < pct);
        @(posedge clk);
      end
    end
  end

  // Offer one reading and hold it until the block takes it
  task automatic offer_reading(logic [D_W-1:0] raw_p, logic [D_W-1:0] raw_t);
    in_valid <= 1'b1;
    in_raw_pressure <= raw_p;
    in_raw_temperature <= raw_t;
    do @(posedge clk); while (in_stall);
    sb.note_input(raw_p, raw_t);
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (sb.pending_readings.size() != 0) @(posedge clk);
  endtask

  // Load all seven words while idle; optionally seal the PROM with a good CRC
  task automatic load_calibration(coef_t c, bit crc_good);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (crc_good) c.prom0[15:12] = sb.crc4_of(c);
    write_reg(REG_PROM0, c.prom0);
    write_reg(REG_C1, c.c1);
    write_reg(REG_C2, c.c2);
    write_reg(REG_C3, c.c3);
    write_reg(REG_C4, c.c4);
    write_reg(REG_C5, c.c5);
    write_reg(REG_C6, c.c6);
    if ($urandom_range(1) == 1) begin
      write_reg(REG_SPARE, REG_W'($urandom()));
      spare_writes++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    cal_sets++;
  endtask

  function automatic logic [REG_W-1:0] coef_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return REG_W'($urandom());
    endcase
  endfunction

  // Random readings in bursts; dense keeps the input saturated
  task automatic random_readings(int count, bit dense);
    int burst;
    longint near_t;
    logic [D_W-1:0] raw_p;
    logic [D_W-1:0] raw_t;
    while (count > 0) begin
      burst = $urandom_range(40, 1);
      if (burst > count) burst = count;
      count -= burst;
      repeat (burst) begin
        raw_p = D_W'($urandom());
        raw_t = D_W'($urandom());
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // temperature near the reference, both sides of the 20 degC split
            near_t = longint'(sb.cal.c5) * 256 +
                     longint'($urandom_range(2 << $urandom_range(20))) -
                     longint'(1 << $urandom_range(20));
            if (near_t < 0) near_t = 0;
            if (near_t > D_MAX) near_t = D_MAX;
            raw_t = near_t[D_W-1:0];
          end
          7: raw_p = $urandom_range(1) ? D_MAX : '0;
          8: raw_t = $urandom_range(1) ? D_MAX : '0;
          9: begin
            raw_p = D_W'(1) << $urandom_range(D_W - 1);
            raw_t = ~(D_W'(1) << $urandom_range(D_W - 1));
          end
          default: ;
        endcase
        offer_reading(raw_p, raw_t);
      end
      if (!dense && $urandom_range(3) != 0) idle_gap($urandom_range(12, 1));
    end
    idle_gap(1);
  endtask

  initial begin : stimulus
    coef_t  c;
    longint ref_t;
    longint step;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset value
    offer_reading('0, '0);
    offer_reading(D_MAX, D_MAX);
    offer_reading('0, D_MAX);
    offer_reading(D_MAX, '0);
    idle_gap(1);
    random_readings(60, 1'b0);

    // Typical calibration with a valid CRC: corners and the 20 degC boundary
    c = '{prom0: 16'h0A5C, c1: 16'd34982, c2: 16'd36352, c3: 16'd20328,
          c4: 16'd22354, c5: 16'd26646, c6: 16'd26146};
    load_calibration(c, 1'b1);
    ref_t = longint'(sb.cal.c5) * 256;
    step = (64'sd8388608 + sb.cal.c6 - 1) / sb.cal.c6;
    offer_reading('0, '0);
    offer_reading(D_MAX, D_MAX);
    offer_reading(24'hAAAAAA, 24'h555555);
    offer_reading(24'h555555, 24'hAAAAAA);
    offer_reading(24'h000001, 24'h000001);
    offer_reading(24'h800000, ref_t[D_W-1:0]);
    offer_reading(D_MAX, D_W'(ref_t - 1));
    offer_reading(D_MAX, D_W'(ref_t + 1));
    offer_reading(24'h7FFFFF, D_W'(ref_t - step));
    offer_reading(24'h7FFFFF, D_W'(ref_t - step + 1));
    offer_reading('0, D_W'(ref_t - step));
    offer_reading(D_MAX, D_W'(ref_t + step));
    idle_gap(1);
    random_readings(200, 1'b0);

    // All coefficients at full scale
    load_calibration('1, 1'b1);
    random_readings(150, 1'b0);

    // Mixed extremes; hold the output off while the input stays saturated
    c = '{prom0: 16'h0000, c1: 16'h0000, c2: 16'hFFFF, c3: 16'hFFFF,
          c4: 16'h0000, c5: 16'hFFFF, c6: 16'hFFFF};
    load_calibration(c, 1'b0);
    holds_asked <= holds_asked + 1;
    random_readings(150, 1'b1);

    c = '{prom0: 16'hFFFF, c1: 16'hFFFF, c2: 16'h0000, c3: 16'h0000,
          c4: 16'hFFFF, c5: 16'h0000, c6: 16'h0001};
    load_calibration(c, 1'b1);
    random_readings(150, 1'b0);

    // Random calibrations, each with an even chance of a sealed CRC
    for (int k = 0; k < 5; k++) begin
      c = '{prom0: coef_word(), c1: coef_word(), c2: coef_word(), c3: coef_word(),
            c4: coef_word(), c5: coef_word(), c6: coef_word()};
      load_calibration(c, $urandom_range(1) == 1);
      if (k == 2) holds_asked <= holds_asked + 1;
      random_readings(140, k == 2);
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (END_WAIT) @(posedge clk);

    $display("Run covered %0d readings over %0d calibration sets,", sb.checked, cal_sets);
    $display("with %0d writes to the unused index and %0d long output hold-offs.",
             spare_writes, holds_asked);
    if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pscomp_pkg.sv
hdl/pscomp_cfg.sv
hdl/pscomp_crc.sv
hdl/pscomp_dp.sv
hdl/pressure_sensor_compensation_top.sv
bench/tb_pressure_sensor_compensation_top.sv
